/* hw/rtl/gn3_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gn3_pkg
// Permutation table and gradient selection shared by the noise pipeline.
// ----------------------------------------------------------------------------
package gn3_pkg;

	localparam int PERM_N = 256;

	typedef logic [7:0] perm_t;

	localparam perm_t PERM_ROM [PERM_N] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
		8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
		8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
		8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
		8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
		8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
		8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
		8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
		8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
		8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
		8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
		8'd215,8'd61,8'd156,8'd180
	};

	function automatic perm_t perm(input perm_t idx);
		return PERM_ROM[idx];
	endfunction

	// Gradient select: bit4 u sign, bit3 v sign, bit2 u is y, bits1:0 v source
	localparam logic [1:0] VSEL_X = 2'd0;
	localparam logic [1:0] VSEL_Y = 2'd1;
	localparam logic [1:0] VSEL_Z = 2'd2;

	typedef struct packed {
		logic       neg_u;
		logic       neg_v;
		logic       u_is_y;
		logic [1:0] vsel;
	} grad_sel_t;

	function automatic grad_sel_t grad_decode(input perm_t hash);
		grad_sel_t  g;
		logic [3:0] h;
		h        = hash[3:0];
		g.neg_u  = h[0];
		g.neg_v  = h[1];
		g.u_is_y = ~h[3];
		g.u_is_y = ~g.u_is_y;
		if (h < 4'd4)
			g.vsel = VSEL_Y;
		else if (h == 4'd12 || h == 4'd14)
			g.vsel = VSEL_X;
		else
			g.vsel = VSEL_Z;
		return g;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/gn3_fade.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gn3_fade
// Pipelined quintic fade 6t^5-15t^4+10t^3, four register stages.
// ----------------------------------------------------------------------------
module gn3_fade #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [FRAC_BITS-1:0] f,
	output logic      [FRAC_BITS:0]   fade
);
	localparam int FB = FRAC_BITS;
	localparam logic [2*FB+4:0] HALF = (2*FB+5)'(1) << (FB-1);

	logic [FB-1:0]   f_s1;
	logic [FB:0]     s_s1;
	logic [FB:0]     c_s2;
	logic [FB+3:0]   g_s2;
	logic [2*FB+4:0] p_s3;
	logic [FB:0]     fade_s4;

	logic [2*FB:0]   sq, cu;
	logic [2*FB+4:0] pr;

	assign sq = (2*FB+1)'(f) * (2*FB+1)'(f);
	assign cu = (2*FB+1)'(s_s1) * (2*FB+1)'(f_s1);
	assign pr = (2*FB+5)'(c_s2) * (2*FB+5)'(g_s2);

	// s1: square, s2: cube and g, s3: c*g product, s4: round
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1    <= f;
			s_s1    <= (FB+1)'((sq + (2*FB+1)'(HALF)) >> FB);
			c_s2    <= (FB+1)'((cu + (2*FB+1)'(HALF)) >> FB);
			g_s2    <= (FB+4)'(10) * ((FB+4)'(1) << FB) + (FB+4)'(6) * (FB+4)'(s_s1)
				- (FB+4)'(15) * (FB+4)'(f_s1);
			p_s3    <= pr;
			fade_s4 <= (FB+1)'((p_s3 + HALF) >> FB);
		end
	end

	assign fade = fade_s4;
endmodule
`default_nettype wire

/* hw/rtl/gn3_lerp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gn3_lerp
// Registered lerp a + rnd(t*(b-a)), two stages.
// ----------------------------------------------------------------------------
module gn3_lerp #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic        [FRAC_BITS:0]   t,
	input  wire logic signed [FRAC_BITS+3:0] a,
	input  wire logic signed [FRAC_BITS+3:0] b,
	output logic signed      [FRAC_BITS+3:0] y
);
	localparam int FB = FRAC_BITS;
	localparam int PW = 2*FB+6;

	logic signed [PW-1:0]   p_s1;
	logic signed [FB+3:0]   a_s1;
	logic signed [FB+3:0]   y_s2;
	logic signed [PW-1:0]   pr;
	logic signed [PW-1:0]   ps;

	assign pr = $signed({1'b0, t}) * (PW)'(b - a);
	assign ps = p_s1 + (PW)'(64'sd1 <<< (FB-1));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= pr;
			a_s1 <= a;
			y_s2 <= a_s1 + (FB+4)'(ps >>> FB);
		end
	end

	assign y = y_s2;
endmodule
`default_nettype wire

/* hw/rtl/gradient_noise_3d.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Improved 3D gradient noise, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One point per clock. Each coordinate carries 8 integer bits (taken
// modulo 256) above FRAC_BITS fraction bits; higher bits are ignored. The
// result is signed with FRAC_BITS fraction bits. Three hash levels through
// the permutation ROM and the gradient stage run beside the four-stage
// fade, then three lerp levels of two stages each. The whole pipe advances
// together and freezes while the output is stalled with a result waiting;
// the input stalls in those same cycles, even when earlier stages hold
// bubbles.
// ----------------------------------------------------------------------------
module gradient_noise_3d
	import gn3_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [23:0]                 coord_x,
	input  wire logic [23:0]                 coord_y,
	input  wire logic [23:0]                 coord_z,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [FRAC_BITS+1:0]      noise_value
);
	localparam int FB  = FRAC_BITS;
	localparam int GW  = FB + 4;     // signed gradient / lerp width
	localparam int LAT = 10;

	// ---------------- pipeline control ----------------
	logic [LAT-1:0] vld_q;
	logic           en;
	// global enable: pipe moves unless the last stage holds a stalled result
	assign en        = ~(vld_q[LAT-1] & out_stall);
	assign in_stall  = ~en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// ---------------- stage 1: split, first hash level ----------------
	logic [FB-1:0] fx, fy, fz;
	perm_t         ix, iy, iz;
	assign fx = coord_x[FB-1:0];
	assign fy = coord_y[FB-1:0];
	assign fz = coord_z[FB-1:0];
	assign ix = coord_x[FB+7:FB];
	assign iy = coord_y[FB+7:FB];
	assign iz = coord_z[FB+7:FB];

	perm_t a_s1, b_s1, z_s1;
	logic [FB-1:0] fx_s1, fy_s1, fz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= perm(ix) + iy;
			b_s1  <= perm(ix + 8'd1) + iy;
			z_s1  <= iz;
			fx_s1 <= fx;
			fy_s1 <= fy;
			fz_s1 <= fz;
		end
	end

	// stage 2: second hash level
	perm_t aa_s2, ab_s2, ba_s2, bb_s2;
	logic [FB-1:0] fx_s2, fy_s2, fz_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			aa_s2 <= perm(a_s1) + z_s1;
			ab_s2 <= perm(a_s1 + 8'd1) + z_s1;
			ba_s2 <= perm(b_s1) + z_s1;
			bb_s2 <= perm(b_s1 + 8'd1) + z_s1;
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			fz_s2 <= fz_s1;
		end
	end

	// stage 3: corner hashes decoded to gradient selects
	// corner k: bit0 = x side, bit1 = y side, bit2 = z side
	grad_sel_t     gs_s3 [8];
	logic [FB-1:0] fx_s3, fy_s3, fz_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			gs_s3[0] <= grad_decode(perm(aa_s2));
			gs_s3[1] <= grad_decode(perm(ba_s2));
			gs_s3[2] <= grad_decode(perm(ab_s2));
			gs_s3[3] <= grad_decode(perm(bb_s2));
			gs_s3[4] <= grad_decode(perm(aa_s2 + 8'd1));
			gs_s3[5] <= grad_decode(perm(ba_s2 + 8'd1));
			gs_s3[6] <= grad_decode(perm(ab_s2 + 8'd1));
			gs_s3[7] <= grad_decode(perm(bb_s2 + 8'd1));
			fx_s3    <= fx_s2;
			fy_s3    <= fy_s2;
			fz_s3    <= fz_s2;
		end
	end

	// stage 4: corner gradients
	logic signed [GW-1:0] g_s4 [8];
	logic signed [GW-1:0] ox0, oy0, oz0, one_s;
	assign one_s = GW'(1) << FB;
	assign ox0   = GW'(fx_s3);
	assign oy0   = GW'(fy_s3);
	assign oz0   = GW'(fz_s3);

	always_ff @(posedge clk) begin
		for (int k = 0; k < 8; k++) begin
			logic signed [GW-1:0] ox, oy, oz, u, v, r;
			ox = k[0] ? ox0 - one_s : ox0;
			oy = k[1] ? oy0 - one_s : oy0;
			oz = k[2] ? oz0 - one_s : oz0;
			u  = gs_s3[k].u_is_y ? oy : ox;
			case (gs_s3[k].vsel)
				VSEL_X:  v = ox;
				VSEL_Y:  v = oy;
				default: v = oz;
			endcase
			r = gs_s3[k].neg_u ? -u : u;
			if (en)
				g_s4[k] <= gs_s3[k].neg_v ? r - v : r + v;
		end
	end

	// fades: four stages, aligned with stage 4 gradients
	logic [FB:0] fu, fv, fw;
	gn3_fade #(.FRAC_BITS(FB)) u_fade_x (.clk(clk), .en(en), .f(fx), .fade(fu));
	gn3_fade #(.FRAC_BITS(FB)) u_fade_y (.clk(clk), .en(en), .f(fy), .fade(fv));
	gn3_fade #(.FRAC_BITS(FB)) u_fade_z (.clk(clk), .en(en), .f(fz), .fade(fw));

	// v and w wait in delay registers (v_s5, v_s6; w_s5 to w_s8) for the later lerp levels
	logic [FB:0] v_s5, v_s6, w_s5, w_s6, w_s7, w_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			v_s5 <= fv;
			v_s6 <= v_s5;
			w_s5 <= fw;
			w_s6 <= w_s5;
			w_s7 <= w_s6;
			w_s8 <= w_s7;
		end
	end

	// lerp level 1 along x: stages 5-6
	logic signed [GW-1:0] l_x [4];
	for (genvar j = 0; j < 4; j++) begin : g_lx
		gn3_lerp #(.FRAC_BITS(FB)) u_lerp (
			.clk(clk), .en(en), .t(fu),
			.a(g_s4[2*j]), .b(g_s4[2*j+1]), .y(l_x[j])
		);
	end

	// level 2 along y: stages 7-8
	logic signed [GW-1:0] l_y [2];
	for (genvar j = 0; j < 2; j++) begin : g_ly
		gn3_lerp #(.FRAC_BITS(FB)) u_lerp (
			.clk(clk), .en(en), .t(v_s6),
			.a(l_x[2*j]), .b(l_x[2*j+1]), .y(l_y[j])
		);
	end

	// level 3 along z: stages 9-10
	logic signed [GW-1:0] l_z;
	gn3_lerp #(.FRAC_BITS(FB)) u_lerp_z (
		.clk(clk), .en(en), .t(w_s8),
		.a(l_y[0]), .b(l_y[1]), .y(l_z)
	);

	// saturate to the output range
	localparam logic signed [GW-1:0] RMAX = (GW'(1) << (FB+1)) - GW'(1);
	localparam logic signed [GW-1:0] RMIN = -(GW'(1) << (FB+1));
	always_comb begin
		if (l_z > RMAX)
			noise_value = (FB+2)'(RMAX);
		else if (l_z < RMIN)
			noise_value = (FB+2)'(RMIN);
		else
			noise_value = (FB+2)'(l_z);
	end
endmodule
`default_nettype wire

/* tb/tb_gradient_noise_3d.sv */
// ----------------------------------------------------------------------------
// tb_gradient_noise_3d
// Self-checking bench for the 3D gradient noise pipeline.
// ----------------------------------------------------------------------------
// Points are sent over the valid/stall input channel; a fixed-point model of
// the improved noise (quintic fade, hashed gradients, seven lerps) predicts
// each value, and a checker compares results in order. Both sides idle in
// random bursts, and one long output hold-off fills the pipe.
// ----------------------------------------------------------------------------
module tb_gradient_noise_3d
	import gn3_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = 16;
	localparam int OUT_W     = FRAC_BITS + 2;
	localparam int LATENCY   = 10;
	localparam int WDOG_MAX  = 5000;
	localparam longint ONE   = 64'sd1 <<< FRAC_BITS;
	localparam longint HALF  = ONE / 2;

	typedef logic signed [OUT_W-1:0] noise_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [23:0] coord_x;
	logic [23:0] coord_y;
	logic [23:0] coord_z;
	logic        out_valid;
	logic        out_stall;
	noise_t      noise_value;

	gradient_noise_3d #(.FRAC_BITS(FRAC_BITS)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.noise_value(noise_value)
	);

	// predicted noise values, oldest first
	noise_t expected_noise[$];
	int     mismatches;
	int     checked;
	int     sent;
	int     idle_cycles;
	bit     timed_out;
	// out-side control
	bit     rx_idle_en;
	bit     rx_hold;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- model
	// floor((p + ONE/2) / ONE); arithmetic shift gives floor for negatives too
	function automatic longint fx_round(longint p);
		return (p + HALF) >>> FRAC_BITS;
	endfunction

	function automatic longint fade_curve(longint f);
		longint sq, cu, g;
		sq = fx_round(f * f);
		cu = fx_round(sq * f);
		g  = 10 * ONE + 6 * sq - 15 * f;
		return fx_round(cu * g);
	endfunction

	function automatic longint blend(longint t, longint a, longint b);
		return a + fx_round(t * (b - a));
	endfunction

	// hash nibble picks one of the cube's edge directions, some of them twice
	function automatic longint corner_dot(logic [7:0] hash, longint dx, longint dy,
			longint dz);
		logic [3:0] h;
		longint     a, b;
		h = hash[3:0];
		a = (h < 4'd8) ? dx : dy;
		b = (h < 4'd4) ? dy : ((h == 4'd12 || h == 4'd14) ? dx : dz);
		if (h[0])
			a = -a;
		return h[1] ? a - b : a + b;
	endfunction

	function automatic noise_t predict_noise(logic [23:0] px, logic [23:0] py,
			logic [23:0] pz);
		logic [7:0] cx, cy, cz, ha, hb, haa, hab, hba, hbb;
		longint     fx, fy, fz, gx, gy, gz, su, sv, sw, l0, l1, l2, l3, r;
		cx = px[FRAC_BITS +: 8];
		cy = py[FRAC_BITS +: 8];
		cz = pz[FRAC_BITS +: 8];
		fx = longint'(px[FRAC_BITS-1:0]);
		fy = longint'(py[FRAC_BITS-1:0]);
		fz = longint'(pz[FRAC_BITS-1:0]);
		gx = fx - ONE;
		gy = fy - ONE;
		gz = fz - ONE;
		su = fade_curve(fx);
		sv = fade_curve(fy);
		sw = fade_curve(fz);
		// 8-bit sums wrap, which mirrors the 8-bit indexing of the 256-entry table
		ha  = PERM_ROM[cx] + cy;
		hb  = PERM_ROM[8'(cx + 8'd1)] + cy;
		haa = PERM_ROM[ha] + cz;
		hab = PERM_ROM[8'(ha + 8'd1)] + cz;
		hba = PERM_ROM[hb] + cz;
		hbb = PERM_ROM[8'(hb + 8'd1)] + cz;
		l0 = blend(su, corner_dot(PERM_ROM[haa], fx, fy, fz),
			corner_dot(PERM_ROM[hba], gx, fy, fz));
		l1 = blend(su, corner_dot(PERM_ROM[hab], fx, gy, fz),
			corner_dot(PERM_ROM[hbb], gx, gy, fz));
		l2 = blend(su, corner_dot(PERM_ROM[8'(haa + 8'd1)], fx, fy, gz),
			corner_dot(PERM_ROM[8'(hba + 8'd1)], gx, fy, gz));
		l3 = blend(su, corner_dot(PERM_ROM[8'(hab + 8'd1)], fx, gy, gz),
			corner_dot(PERM_ROM[8'(hbb + 8'd1)], gx, gy, gz));
		r = blend(sw, blend(sv, l0, l1), blend(sv, l2, l3));
		if (r > 2 * ONE - 1)
			r = 2 * ONE - 1;
		if (r < -2 * ONE)
			r = -2 * ONE;
		return noise_t'(r);
	endfunction

	// ---------------------------------------------------------------- checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_noise.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected noise value %0d", noise_value);
			end else begin
				noise_t want;
				want = expected_noise.pop_front();
				checked++;
				if (noise_value !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: noise_value expected %0d got %0d", want,
							noise_value);
				end
			end
		end
	end

	// receiver: random stall bursts, or a long hold-off on request
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_stall <= 1'b1;
				repeat (60) @(negedge clk);
				out_stall <= 1'b0;
				rx_hold = 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 16);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: cycles with no accepted item on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX && !timed_out) begin
			timed_out = 1'b1;
			$display("gradient_noise_3d verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sender
	bit tx_idle_en;

	// in_valid stays high after an accept so points can follow back to back
	task automatic send_point(logic [23:0] px, logic [23:0] py, logic [23:0] pz);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid <= 1'b1;
		coord_x  <= px;
		coord_y  <= py;
		coord_z  <= pz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_noise.push_back(predict_noise(px, py, pz));
		sent++;
		@(negedge clk);
	endtask

	function automatic logic [23:0] rand_coord();
		logic [23:0] c;
		c = 24'($urandom);
		case ($urandom_range(0, 7))
			0: c[15:0] = 16'h0000;
			1: c[15:0] = 16'hFFFF;
			2: c[15:0] = 16'h8000;
			default: ;
		endcase
		return c;
	endfunction

	// ---------------------------------------------------------------- tests
	task automatic test_corners();
		send_point(24'h0, 24'h0, 24'h0);
		send_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_point(24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
		send_point(24'h008000, 24'h008000, 24'h008000);
		send_point(24'hFF0000, 24'h000001, 24'h7F8000);
		// same fraction bits in different cells
		send_point(24'h123456, 24'h00ABCD, 24'h804321);
		send_point(24'h023456, 24'hFFABCD, 24'h7F4321);
		send_point(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
		send_point(24'h555555, 24'hAAAAAA, 24'h555555);
	endtask

	// walk cells to vary the gradient hash values seen at the corners
	task automatic test_gradients();
		for (int i = 0; i < 14; i++)
			send_point({8'(i * 19), 16'h4000 + 16'(i * 911)},
				{8'(i * 7), 16'hC000 - 16'(i * 503)}, {8'(i * 37), 16'(i * 4679)});
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_point(rand_coord(), rand_coord(), rand_coord());
	endtask

	// receiver holds off long while the sender keeps offering points
	task automatic test_backpressure();
		rx_hold = 1'b1;
		test_random(40);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_noise.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		coord_x     = '0;
		coord_y     = '0;
		coord_z     = '0;
		mismatches  = 0;
		checked     = 0;
		sent        = 0;
		idle_cycles = 0;
		timed_out   = 1'b0;
		rx_idle_en  = 1'b0;
		rx_hold     = 1'b0;
		tx_idle_en  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_corners();
		test_gradients();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		test_random(250);
		test_backpressure();
		// last stretch at full rate, no idling
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random(80);
		drain();

		if (expected_noise.size() != 0)
			mismatches++;
		$display("Sent %0d points (corners, hash walk, random, back-pressure);", sent);
		$display("checked %0d noise values, %0d mismatches.", checked, mismatches);
		if (mismatches == 0)
			$display("gradient_noise_3d verification clean");
		else
			$display("gradient_noise_3d verification failed");
		$finish;
	end

endmodule
